### hdl/plgp_pkg.sv
// Shared types, constants and elaboration-time helpers for the power-law gamma pixel unit.
`default_nettype none

package plgp_pkg;

  // Default full-scale pixel value.
  localparam int unsigned PIXEL_MAX_DEF = 255;

  // Fraction bits of the fixed-point log values.
  localparam int unsigned LOG_FRAC = 24;

  // Value 1.0 in the Q30 power format.
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 8'd1;
  localparam logic [15:0] GAIN_RST     = 16'd1024;
  localparam logic [15:0] EXPONENT_RST = 16'd1024;

  // Configuration register values handed to the table builder.
  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] exponent;
  } plgp_cfg_t;

  // One table entry: clamp flag and corrected pixel.
  typedef struct packed {
    logic       clamped;
    logic [7:0] pixel;
  } plgp_ent_t;

  // Write request from the table builder into the result table.
  typedef struct packed {
    logic      we;
    logic [7:0] addr;
    plgp_ent_t  data;
  } plgp_wr_t;

  // Roots 2^(-2^-k) for k = 1 .. LOG_FRAC, in Q30.
  typedef logic [LOG_FRAC-1:0][29:0] plgp_root_tab_t;

  // Integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xv;
    logic [63:0] r;
    logic [63:0] b;
    xv = x;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (xv >= r + b) begin
        xv = xv - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Builds the table of roots by repeated square roots, at elaboration only.
  function automatic plgp_root_tab_t build_roots();
    plgp_root_tab_t tab;
    logic [63:0]    s;
    s = 64'h2000_0000;
    for (int k = 0; k < LOG_FRAC; k++) begin
      s = isqrt64(s << 30);
      tab[k] = s[29:0];
    end
    return tab;
  endfunction

  localparam plgp_root_tab_t ROOT_TAB = build_roots();

  // log2 of x (1 .. 65535) as unsigned Q4.24, evaluated at elaboration only.
  function automatic logic [27:0] log2_q24(input logic [31:0] x);
    logic [4:0]  n;
    logic [63:0] m;
    logic [27:0] res;
    n = '0;
    for (int i = 1; i < 32; i++) begin
      if ((x >> i) != 32'd0) begin
        n = 5'(i);
      end
    end
    m   = 64'(x) << (5'd30 - n);
    res = {n[3:0], 24'd0};
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m      = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/plgp_build.sv
// Table builder: computes the corrected value of every pixel code on one shared multiplier.
`default_nettype none

module plgp_build #(
  parameter int unsigned PIXEL_MAX = plgp_pkg::PIXEL_MAX_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  plgp_pkg::plgp_cfg_t cfg_i,
  input  wire                 restart_i,
  output plgp_pkg::plgp_wr_t  wr_o,
  output logic                busy_o
);

  localparam logic [15:0] PM16    = 16'(PIXEL_MAX);
  localparam logic [31:0] PM32    = 32'(PIXEL_MAX);
  localparam logic [27:0] LOG_MAX = plgp_pkg::log2_q24(PM32);
  localparam logic [4:0]  LAST    = 5'(plgp_pkg::LOG_FRAC - 1);
  localparam logic [63:0] HALF_40 = 64'h0000_0080_0000_0000;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_GP    = 8'b0000_0010,
    ST_INIT  = 8'b0000_0100,
    ST_LOG   = 8'b0000_1000,
    ST_MULE  = 8'b0001_0000,
    ST_EXP   = 8'b0010_0000,
    ST_SHIFT = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } plgp_state_e;

  plgp_state_e state_q, state_d;
  logic [7:0]  addr_q, addr_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] gp_q, gp_d;
  logic [30:0] m_q, m_d;
  logic [2:0]  n_q, n_d;
  logic [23:0] lfr_q, lfr_d;
  logic [23:0] fr_q, fr_d;
  logic [9:0]  ip_q, ip_d;
  logic [30:0] v_q, v_d;
  logic [30:0] pw_q, pw_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [7:0]  pc;
  logic [2:0]  n_init;
  logic [30:0] m_init;
  logic [27:0] d;
  logic [31:0] sq;
  logic [43:0] e_sum;
  logic [63:0] r_sum;
  logic [23:0] res;
  logic        clamp;

  // Pixel code clipped to full scale and its normalized mantissa.
  always_comb begin
    pc = ({8'd0, addr_q} > PM16) ? PM16[7:0] : addr_q;
    n_init = '0;
    for (int i = 0; i < 8; i++) begin
      if (pc[i]) begin
        n_init = 3'(i);
      end
    end
    m_init = 31'(pc) << (5'd30 - {2'b00, n_init});
  end

  // Log distance from full scale.
  assign d = LOG_MAX - {1'b0, n_q, lfr_q};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_GP: begin
        mul_a = {16'd0, cfg_i.gain};
        mul_b = PM32;
      end
      ST_LOG: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      ST_MULE: begin
        mul_a = {4'd0, d};
        mul_b = {16'd0, cfg_i.exponent};
      end
      ST_EXP: begin
        mul_a = {1'b0, v_q};
        mul_b = {2'b00, plgp_pkg::ROOT_TAB[cnt_q]};
      end
      ST_FIN: begin
        mul_a = {1'b0, pw_q};
        mul_b = gp_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Derived views of the product.
  assign sq    = mul_p[61:30];
  assign e_sum = mul_p[43:0] + 44'd512;
  assign r_sum = mul_p + HALF_40;
  assign res   = r_sum[63:40];
  assign clamp = res > {8'd0, PM16};

  // Sequencer and datapath next values.
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    gp_d    = gp_q;
    m_d     = m_q;
    n_d     = n_q;
    lfr_d   = lfr_q;
    fr_d    = fr_q;
    ip_d    = ip_q;
    v_d     = v_q;
    pw_d    = pw_q;
    wr_o.we            = 1'b0;
    wr_o.addr          = addr_q;
    wr_o.data.clamped  = clamp;
    wr_o.data.pixel    = clamp ? PM16[7:0] : res[7:0];
    case (state_q)
      ST_IDLE: begin
        state_d = ST_IDLE;
      end
      ST_GP: begin
        gp_d    = mul_p[31:0];
        addr_d  = '0;
        state_d = ST_INIT;
      end
      ST_INIT: begin
        if (cfg_i.exponent == 16'd0) begin
          pw_d    = plgp_pkg::ONE_Q30;
          state_d = ST_FIN;
        end else if (pc == 8'd0) begin
          pw_d    = '0;
          state_d = ST_FIN;
        end else begin
          m_d     = m_init;
          n_d     = n_init;
          lfr_d   = '0;
          cnt_d   = '0;
          state_d = ST_LOG;
        end
      end
      ST_LOG: begin
        m_d   = sq[31] ? sq[31:1] : sq[30:0];
        lfr_d = {lfr_q[22:0], sq[31]};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == LAST) begin
          state_d = ST_MULE;
        end
      end
      ST_MULE: begin
        ip_d    = e_sum[43:34];
        fr_d    = e_sum[33:10];
        v_d     = plgp_pkg::ONE_Q30;
        cnt_d   = '0;
        state_d = ST_EXP;
      end
      ST_EXP: begin
        if (fr_q[23]) begin
          v_d = mul_p[60:30];
        end
        fr_d  = {fr_q[22:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == LAST) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        pw_d    = (ip_q >= 10'd31) ? '0 : (v_q >> ip_q[4:0]);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        wr_o.we = 1'b1;
        if (addr_q == 8'hFF) begin
          state_d = ST_IDLE;
        end else begin
          addr_d  = addr_q + 8'd1;
          state_d = ST_INIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // A register write starts the table over.
    if (restart_i) begin
      state_d = ST_GP;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_GP;
      addr_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    gp_q  <= gp_d;
    m_q   <= m_d;
    n_q   <= n_d;
    lfr_q <= lfr_d;
    fr_q  <= fr_d;
    ip_q  <= ip_d;
    v_q   <= v_d;
    pw_q  <= pw_d;
  end

  // A register write always restarts the sweep at the gain product.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_i |=> state_q == ST_GP)
    else $error("builder did not restart after a register write");

  // The squared mantissa stays normalized to [1, 2) during the log steps.
  a_log_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOG |-> m_q[30])
    else $error("log mantissa lost normalization");

  // The running power never exceeds 1.0.
  a_pow_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXP |-> v_q <= plgp_pkg::ONE_Q30)
    else $error("power value exceeded one");

endmodule

`default_nettype wire

### hdl/plgp_lut.sv
// Result table memory with the pixel request path and its output stages.
`default_nettype none

module plgp_lut (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  plgp_pkg::plgp_wr_t wr_i,
  input  wire                busy_i,
  input  wire                in_valid_i,
  input  wire  [7:0]         in_pixel_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [7:0]         out_pixel_o,
  output logic               clamped_o
);

  plgp_pkg::plgp_ent_t mem_q [256];
  plgp_pkg::plgp_ent_t rd_q;
  plgp_pkg::plgp_ent_t out_q;
  logic                s1_valid_q;
  logic                out_valid_q;
  logic                s2_free;
  logic                s1_adv;
  logic                rd_en;

  // Handshake: the read stage and the output register form a two-deep queue.
  assign s2_free    = ~out_valid_q | ~out_stall_i;
  assign s1_adv     = s1_valid_q & s2_free;
  assign in_stall_o = busy_i | (s1_valid_q & ~s1_adv);
  assign rd_en      = in_valid_i & ~in_stall_o;

  // Table writes from the builder.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered table read for each accepted request.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[in_pixel_i];
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= rd_q;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= rd_en | (s1_valid_q & ~s1_adv);
      if (s2_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_q.pixel;
  assign clamped_o   = out_q.clamped;

  // The table is never read in a cycle in which the builder writes it.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.we |-> !rd_en)
    else $error("table read while it is being rebuilt");

endmodule

`default_nettype wire

### hdl/power_law_gamma_pixel_unit.sv
// Top level of the power-law gamma pixel unit: configuration registers, builder and table.
//
// Each pixel request returns round(gain * (p / PIXEL_MAX)^exponent * PIXEL_MAX), saturated at
// PIXEL_MAX with a clamp flag, from a 256-entry result table held in one synchronous memory.
// Once the table is built the unit takes one pixel every clock while the output does not stall;
// each result is registered in the read stage and then in the output register, and the read
// stage and the output register let a new request in while a result waits on a stalled output.
// After reset and after every write to gain or exponent, a builder with one shared 32x32
// multiplier recomputes all 256 entries, each in 24 log squaring steps, 24 root multiplies and
// four more steps (only the init and final steps for black or a zero exponent), and the pixel
// channel is stalled until it finishes. Register writes are taken at any time; a write to an
// index beyond exponent is ignored.
`default_nettype none

module power_law_gamma_pixel_unit #(
  parameter int unsigned PIXEL_MAX = plgp_pkg::PIXEL_MAX_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [plgp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [15:0]                     cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [7:0]                      in_pixel_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [7:0]                      out_pixel_o,
  output logic                            clamped_o
);

  logic [15:0]         gain_q;
  logic [15:0]         exponent_q;
  logic                restart;
  logic                busy;
  plgp_pkg::plgp_cfg_t cfg;
  plgp_pkg::plgp_wr_t  wr;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign restart     = cfg_valid_i & ((cfg_index_i == plgp_pkg::REG_GAIN) |
                                      (cfg_index_i == plgp_pkg::REG_EXPONENT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q     <= plgp_pkg::GAIN_RST;
      exponent_q <= plgp_pkg::EXPONENT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == plgp_pkg::REG_GAIN) begin
        gain_q <= cfg_data_i;
      end
      if (cfg_index_i == plgp_pkg::REG_EXPONENT) begin
        exponent_q <= cfg_data_i;
      end
    end
  end

  assign cfg.gain     = gain_q;
  assign cfg.exponent = exponent_q;

  // Table builder.
  plgp_build #(
    .PIXEL_MAX (PIXEL_MAX)
  ) u_build (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .wr_o      (wr),
    .busy_o    (busy)
  );

  // Result table and pixel path.
  plgp_lut u_lut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .busy_i      (busy),
    .in_valid_i  (in_valid_i),
    .in_pixel_i  (in_pixel_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pixel_o (out_pixel_o),
    .clamped_o   (clamped_o)
  );

endmodule

`default_nettype wire
